FILE: rtl/sbr_pkg.sv
package sbr_pkg;

  // sentence break classes
  localparam logic [3:0] SB_OTHER     = 4'd0;
  localparam logic [3:0] SB_CR        = 4'd1;
  localparam logic [3:0] SB_LF        = 4'd2;
  localparam logic [3:0] SB_EXTEND    = 4'd3;
  localparam logic [3:0] SB_SEP       = 4'd4;
  localparam logic [3:0] SB_FORMAT    = 4'd5;
  localparam logic [3:0] SB_SP        = 4'd6;
  localparam logic [3:0] SB_LOWER     = 4'd7;
  localparam logic [3:0] SB_UPPER     = 4'd8;
  localparam logic [3:0] SB_OLETTER   = 4'd9;
  localparam logic [3:0] SB_NUMERIC   = 4'd10;
  localparam logic [3:0] SB_ATERM     = 4'd11;
  localparam logic [3:0] SB_STERM     = 4'd12;
  localparam logic [3:0] SB_CLOSE     = 4'd13;
  localparam logic [3:0] SB_SCONTINUE = 4'd14;
  localparam logic [3:0] SB_INVALID   = 4'd15;

  // boundary codes
  localparam logic [1:0] BND_NONE     = 2'd0;
  localparam logic [1:0] BND_NO_BREAK = 2'd1;
  localparam logic [1:0] BND_BREAK    = 2'd2;
  localparam logic [1:0] BND_PENDING  = 2'd3;

  // rule context carried from item to item
  // have_set: bit 0 this class, bit 1 last class, bit 2 class before last
  typedef struct packed {
    logic [3:0] class_before_last;
    logic [3:0] last_class;
    logic [3:0] this_class;
    logic [2:0] have_set;
    logic       merge_mark;
    logic       in_terminator;
    logic       terminator_has_space;
    logic       terminator_is_aterm;
    logic       lookahead_pending;
    logic       pending_fallback_break;
  } sbr_ctx_t;

  // decision for one item
  typedef struct packed {
    logic [1:0] boundary;
    logic       resolve_valid;
    logic       resolve_break;
  } sbr_result_t;

  function automatic logic is_parasep(input logic [3:0] c);
    return (c == SB_SEP) || (c == SB_CR) || (c == SB_LF);
  endfunction

  function automatic logic is_blocker(input logic [3:0] c);
    return (c == SB_OLETTER) || (c == SB_UPPER) || (c == SB_LOWER) ||
           is_parasep(c) || (c == SB_STERM) || (c == SB_ATERM);
  endfunction

endpackage

FILE: rtl/sbr_rules.sv
module sbr_rules import sbr_pkg::*; (
  input  sbr_ctx_t    ctx,
  input  logic        mode,
  input  logic        text_start,
  input  logic [3:0]  sb_class,
  output sbr_ctx_t    ctx_next,
  output sbr_result_t res
);

  logic [3:0] c;
  logic       p_in;
  logic       p_sp;
  logic       p_at;
  logic [1:0] fb;

  // out of range class reads as other
  assign c    = (sb_class == SB_INVALID) ? SB_OTHER : sb_class;
  assign p_in = ctx.in_terminator;
  assign p_sp = ctx.terminator_has_space;
  assign p_at = ctx.terminator_is_aterm;

  // fallback rules on the terminator context before this item
  always_comb begin
    if (!p_in) begin
      fb = BND_NO_BREAK;
    end else if (c == SB_SCONTINUE || c == SB_STERM || c == SB_ATERM) begin
      fb = BND_NO_BREAK;
    end else if (c == SB_CLOSE && !p_sp) begin
      fb = BND_NO_BREAK;
    end else if (c == SB_SP || is_parasep(c)) begin
      fb = BND_NO_BREAK;
    end else begin
      fb = BND_BREAK;
    end
  end

  // context update and decision
  always_comb begin
    ctx_next          = ctx;
    res.boundary      = BND_NONE;
    res.resolve_valid = 1'b0;
    res.resolve_break = 1'b0;

    if (mode) begin
      // end of text
      res.resolve_valid = ctx.lookahead_pending;
      res.resolve_break = ctx.lookahead_pending & ctx.pending_fallback_break;
      res.boundary      = ctx.have_set[0] ? BND_BREAK : BND_NONE;
      ctx_next          = '0;
    end else if (text_start || !ctx.have_set[0]) begin
      // first codepoint of a text
      res.resolve_valid            = ctx.lookahead_pending;
      res.resolve_break            = ctx.lookahead_pending & ctx.pending_fallback_break;
      ctx_next                     = '0;
      ctx_next.this_class          = c;
      ctx_next.have_set            = 3'b001;
      ctx_next.in_terminator       = (c == SB_STERM) || (c == SB_ATERM);
      ctx_next.terminator_is_aterm = (c == SB_ATERM);
      res.boundary                 = BND_BREAK;
    end else begin
      // settle a pending look-ahead
      if (ctx.lookahead_pending) begin
        if (c == SB_LOWER) begin
          res.resolve_valid               = 1'b1;
          res.resolve_break               = 1'b0;
          ctx_next.lookahead_pending      = 1'b0;
          ctx_next.pending_fallback_break = 1'b0;
        end else if (is_blocker(c)) begin
          res.resolve_valid               = 1'b1;
          res.resolve_break               = ctx.pending_fallback_break;
          ctx_next.lookahead_pending      = 1'b0;
          ctx_next.pending_fallback_break = 1'b0;
        end
      end

      // shift class history, extend and format stay merged
      if (!ctx.merge_mark) begin
        ctx_next.class_before_last = ctx.last_class;
        ctx_next.have_set          = {ctx.have_set[1], 2'b11};
      end else begin
        ctx_next.have_set          = {ctx.have_set[2], 2'b11};
      end
      ctx_next.merge_mark = 1'b0;
      ctx_next.last_class = ctx.this_class;
      ctx_next.this_class = c;

      if (ctx.this_class == SB_CR && c == SB_LF) begin
        res.boundary = BND_NO_BREAK;
      end else if (is_parasep(ctx.this_class)) begin
        // break after paragraph separator
        ctx_next.in_terminator        = 1'b0;
        ctx_next.terminator_has_space = 1'b0;
        ctx_next.terminator_is_aterm  = 1'b0;
        res.boundary                  = BND_BREAK;
      end else if (c == SB_EXTEND || c == SB_FORMAT) begin
        ctx_next.this_class = ctx.this_class;
        ctx_next.merge_mark = 1'b1;
        res.boundary        = BND_NO_BREAK;
      end else begin
        // terminator sequence tracking
        if (c == SB_STERM || c == SB_ATERM) begin
          ctx_next.in_terminator        = 1'b1;
          ctx_next.terminator_has_space = 1'b0;
          ctx_next.terminator_is_aterm  = (c == SB_ATERM);
        end else if (p_in && c == SB_CLOSE && !p_sp) begin
          ctx_next.in_terminator        = 1'b1;
          ctx_next.terminator_has_space = 1'b0;
          ctx_next.terminator_is_aterm  = p_at;
        end else if (p_in && c == SB_SP) begin
          ctx_next.in_terminator        = 1'b1;
          ctx_next.terminator_has_space = 1'b1;
          ctx_next.terminator_is_aterm  = p_at;
        end else begin
          ctx_next.in_terminator        = 1'b0;
          ctx_next.terminator_has_space = 1'b0;
          ctx_next.terminator_is_aterm  = 1'b0;
        end

        if (ctx.this_class == SB_ATERM && c == SB_NUMERIC) begin
          res.boundary = BND_NO_BREAK;
        end else if (ctx_next.have_set[2] &&
                     (ctx_next.class_before_last == SB_UPPER ||
                      ctx_next.class_before_last == SB_LOWER) &&
                     ctx.this_class == SB_ATERM && c == SB_UPPER) begin
          res.boundary = BND_NO_BREAK;
        end else if (p_in && p_at && c == SB_LOWER) begin
          res.boundary = BND_NO_BREAK;
        end else if (p_in && p_at && !is_blocker(c)) begin
          // open look-ahead where the fallback would break
          if (fb == BND_BREAK) begin
            ctx_next.lookahead_pending      = 1'b1;
            ctx_next.pending_fallback_break = 1'b1;
            res.boundary                    = BND_PENDING;
          end else begin
            res.boundary = BND_NO_BREAK;
          end
        end else begin
          res.boundary = fb;
        end
      end
    end
  end

endmodule

FILE: rtl/sentence_boundary_rules_core.sv
// channel | valid    | stall     | payload
// input   | in_valid | in_stall  | mode, text_start, sb_class
// output  | out_valid| out_stall | boundary, resolve_valid, resolve_break
//
// one item per cycle sustained while out_stall is low
// an input register feeds the rule logic, which loads the result register and context
// rst (synchronous) clears context, so the next codepoint starts a new text
// out_stall holds the result register; in_stall rises only when both stages are full
// and out_stall is high
module sentence_boundary_rules_core import sbr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic       text_start,
  input  logic [3:0] sb_class,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] boundary,
  output logic       resolve_valid,
  output logic       resolve_break
);

  logic        s1_valid;
  logic        s1_mode;
  logic        s1_start;
  logic [3:0]  s1_class;
  sbr_ctx_t    ctx;
  sbr_ctx_t    ctx_next;
  sbr_result_t rule_res;
  logic        advance;
  logic        in_take;

  // stage handshake
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  sbr_rules u_rules (
    .ctx        (ctx),
    .mode       (s1_mode),
    .text_start (s1_start),
    .sb_class   (s1_class),
    .ctx_next   (ctx_next),
    .res        (rule_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_take) begin
      s1_mode  <= mode;
      s1_start <= text_start;
      s1_class <= sb_class;
    end
  end

  // context and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        ctx       <= ctx_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      boundary      <= rule_res.boundary;
      resolve_valid <= rule_res.resolve_valid;
      resolve_break <= rule_res.resolve_break;
    end
  end

`ifndef SYNTHESIS
  a_pending_flags: assert property (@(posedge clk) disable iff (rst)
    ctx.lookahead_pending == ctx.pending_fallback_break)
    else $error("pending flags disagree");

  a_break_needs_resolve: assert property (@(posedge clk) disable iff (rst)
    out_valid && resolve_break |-> resolve_valid)
    else $error("resolve_break without resolve_valid");

  a_provisional_opens: assert property (@(posedge clk) disable iff (rst)
    advance && rule_res.boundary == BND_PENDING |=> ctx.lookahead_pending)
    else $error("provisional boundary without pending look-ahead");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("stall with empty input stage");
`endif

endmodule
